// ----- rtl/tia_pkg.sv -----
// Shared types and constants for the table interpolation block.
// Used by the scan cells, the serial divider and the top level.
package tia_pkg;

   localparam int WL_W   = 16;
   localparam int PROB_W = 17;
   localparam int RND_W  = 16;
   localparam int IDX_W  = 6;
   localparam int CNT_IN_W = 7;

   // quotient magnitude stays below 2**17, numerator below 2**33
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 16;
   localparam int QUO_W  = 17;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic CSR_QE_ENABLED  = 1'b0;
   localparam logic CSR_POINT_COUNT = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_DISABLED = 2'd3;

   // query token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic              exact;
      logic              range;
      logic [WL_W-1:0]   lam;
      logic [WL_W-1:0]   pw;
      logic [PROB_W-1:0] pp;
      logic [WL_W-1:0]   hw;
      logic [PROB_W-1:0] hp;
   } tia_token_type;

   // table entry write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [WL_W-1:0]   w;
      logic [PROB_W-1:0] p;
   } tia_load_type;

endpackage

// ----- rtl/table_interpolate_accept_core.sv -----
// Piecewise-linear efficiency table with accept/reject decision.
// Loads and status-only queries skip the chain and go straight to the output stages.
// Interpolated queries pass the cell chain, divider load, 17 divider steps and
// two output stages; exact hits and range misses skip the divider.
// One request in flight; the next is accepted the cycle after the response loads.
// Synchronous reset: qe_enabled 1, point_count 0, nothing pending; entries undefined.
module table_interpolate_accept_core
   import tia_pkg::*;
#(
   parameter int POINTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [WL_W-1:0]     req_wavelength,
   input  logic [PROB_W-1:0]   req_entry_probability,
   input  logic [RND_W-1:0]    req_random_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic [PROB_W-1:0]   rsp_interpolated_probability,
   output logic [1:0]          rsp_status,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [CNT_IN_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(POINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } tia_state_type;

   tia_state_type       state_ff, state_in;
   logic                qe_ff;
   logic [CNT_IN_W-1:0] pc_ff;
   logic [CNT_W-1:0]    n;
   logic                fire;

   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [PROB_W-1:0]   p0_ff, p0_in;
   logic                neg_ff, neg_in;
   logic                res_acc_ff, res_acc_in;
   logic [PROB_W-1:0]   res_prob_ff, res_prob_in;
   logic [1:0]          res_stat_ff, res_stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff;
   logic [PROB_W-1:0]   rsp_prob_ff;
   logic [1:0]          rsp_stat_ff;
   logic                move;

   tia_load_type        load;
   tia_token_type       tok [POINTS+1];
   tia_token_type       chain_out;

   logic signed [PROB_W:0] dp;
   logic [PROB_W-1:0]      dp_mag;
   logic [WL_W-1:0]        dl;
   logic [NUM_W-1:0]       prod;
   logic [DEN_W-1:0]       den;
   logic                   div_start;
   logic                   div_done;
   logic [QUO_W-1:0]       quo;
   logic signed [PROB_W+1:0] qs;
   logic signed [PROB_W+1:0] sum;
   logic [PROB_W-1:0]      prob_c;

   assign fire      = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign n = (32'(pc_ff) > POINTS) ? CNT_W'(POINTS) : CNT_W'(32'(pc_ff));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qe_ff <= 1'b1;
         pc_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_QE_ENABLED:  qe_ff <= csr_wr_data[0];
            CSR_POINT_COUNT: pc_ff <= csr_wr_data;
            default:         pc_ff <= pc_ff;
         endcase
      end
   end

   always_comb begin
      load.en  = fire && (req_func == FUNC_LOAD);
      load.idx = req_entry_index;
      load.w   = req_wavelength;
      load.p   = (req_entry_probability > PROB_ONE) ? PROB_ONE : req_entry_probability;
   end

   always_comb begin
      tok[0]       = '0;
      tok[0].valid = fire && (req_func == FUNC_QUERY) && qe_ff && (pc_ff != '0);
      tok[0].lam   = req_wavelength;
   end

   for (genvar i = 0; i < POINTS; i++) begin : g_cell
      tia_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .load    (load),
         .n       (n),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign chain_out = tok[POINTS];

   // interpolation operands straight off the chain end
   always_comb begin
      dp     = $signed({1'b0, chain_out.hp}) - $signed({1'b0, chain_out.pp});
      dp_mag = dp[PROB_W] ? PROB_W'(-dp) : dp[PROB_W-1:0];
      dl     = chain_out.lam - chain_out.pw;
      prod   = NUM_W'(dp_mag) * NUM_W'(dl);
      den    = chain_out.hw - chain_out.pw;
   end

   assign div_start = (state_ff == S_SCAN) && chain_out.valid
                      && !chain_out.range && !chain_out.exact;

   tia_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (prod),
      .den      (den),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      qs  = $signed({2'b00, quo});
      sum = $signed({2'b00, p0_ff}) + (neg_ff ? -qs : qs);
      priority if (sum < 0) begin
         prob_c = '0;
      end else if (sum > $signed({2'b00, PROB_ONE})) begin
         prob_c = PROB_ONE;
      end else begin
         prob_c = sum[PROB_W-1:0];
      end
   end

   assign move = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      p0_in       = p0_ff;
      neg_in      = neg_ff;
      res_acc_in  = res_acc_ff;
      res_prob_in = res_prob_ff;
      res_stat_in = res_stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               rnd_in      = req_random_value;
               res_acc_in  = 1'b0;
               res_prob_in = '0;
               res_stat_in = ST_OK;
               priority if (req_func == FUNC_LOAD) begin
                  state_in = S_OUT;
               end else if (!qe_ff) begin
                  res_stat_in = ST_DISABLED;
                  state_in    = S_OUT;
               end else if (pc_ff == '0) begin
                  res_stat_in = ST_EMPTY;
                  state_in    = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (chain_out.valid) begin
               priority if (chain_out.range) begin
                  res_stat_in = ST_RANGE;
                  state_in    = S_OUT;
               end else if (chain_out.exact) begin
                  res_prob_in = chain_out.hp;
                  res_acc_in  = ({1'b0, rnd_ff} < chain_out.hp);
                  state_in    = S_OUT;
               end else begin
                  p0_in    = chain_out.pp;
                  neg_in   = dp[PROB_W];
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_prob_in = prob_c;
               res_acc_in  = ({1'b0, rnd_ff} < prob_c);
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (move) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = move ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff      <= rnd_in;
      p0_ff       <= p0_in;
      neg_ff      <= neg_in;
      res_acc_ff  <= res_acc_in;
      res_prob_ff <= res_prob_in;
      res_stat_ff <= res_stat_in;
      if (move) begin
         rsp_acc_ff  <= res_acc_ff;
         rsp_prob_ff <= res_prob_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_accepted                 = rsp_acc_ff;
   assign rsp_interpolated_probability = rsp_prob_ff;
   assign rsp_status                   = rsp_stat_ff;

   a_chain_in_scan : assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> state_ff == S_SCAN)
      else $error("token left the chain outside the scan phase");

   a_div_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide phase");

   a_status_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_interpolated_probability == '0 && !rsp_accepted)
      else $error("error status with nonzero result");

   a_prob_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_interpolated_probability <= PROB_ONE)
      else $error("probability above one");

   a_scan_latency : assert property (@(posedge clock) disable iff (reset)
      tok[0].valid |-> state_in == S_SCAN)
      else $error("query entered the chain without a scan phase");

endmodule

// ----- rtl/tia_cell.sv -----
// One table entry of the scan chain plus its token stage.
// Depends on tia_pkg for the token and load types.
module tia_cell
   import tia_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tia_load_type         load,
   input  logic [CNT_W-1:0]     n,
   input  tia_token_type        tok_in,
   output tia_token_type        tok_out
);

   localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

   logic [WL_W-1:0]   w_ff;
   logic [PROB_W-1:0] p_ff;
   tia_token_type     tok_ff;
   tia_token_type     tok_in_c;
   logic              active;

   always_ff @(posedge clock) begin
      if (load.en && (32'(load.idx) == IDX)) begin
         w_ff <= load.w;
         p_ff <= load.p;
      end
   end

   always_comb begin
      tok_in_c = tok_in;
      active   = tok_in.valid && (IDX_C < n);
      if (active) begin
         if ((IDX == 0) && (tok_in.lam < w_ff)) begin
            tok_in_c.range = 1'b1;
         end
         if ((n == NEXT_C) && (tok_in.lam > w_ff)) begin
            tok_in_c.range = 1'b1;
         end
         if (!tok_in.found) begin
            if (w_ff == tok_in.lam) begin
               tok_in_c.found = 1'b1;
               tok_in_c.exact = 1'b1;
               tok_in_c.hp    = p_ff;
            end else if (w_ff > tok_in.lam) begin
               tok_in_c.found = 1'b1;
               tok_in_c.hw    = w_ff;
               tok_in_c.hp    = p_ff;
            end else begin
               // entry below the query: becomes the lower point
               tok_in_c.pw = w_ff;
               tok_in_c.pp = p_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_c;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/tia_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on tia_pkg for the operand widths.
module tia_divider
   import tia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     sh_ff, sh_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 qbit;

   always_comb begin
      trial   = {rem_ff, sh_ff[QUO_W-1]};
      diff    = trial - {1'b0, den_ff};
      qbit    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high numerator bits are already below the divisor
         rem_in  = num[NUM_W-1:QUO_W];
         sh_in   = num[QUO_W-1:0];
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         sh_in  = {sh_ff[QUO_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule
